@@ sv/bsms_pkg.sv @@
// ----------------------------------------------------------------------------
// bsms_pkg
// Shared types and constants of the BCD stopwatch and display-mode sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package bsms_pkg;

  localparam int unsigned PrescaleW = 16;
  localparam int unsigned PingW     = 8;
  localparam int unsigned ModeW     = 3;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned TensW     = 3;
  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [DigitW-1:0] DigitMax = 4'd9;
  localparam logic [DigitW-1:0] TensMax  = 4'd5;

  // display modes
  localparam logic [ModeW-1:0] ModeStartup = 3'd0;
  localparam logic [ModeW-1:0] ModeLongA   = 3'd1;
  localparam logic [ModeW-1:0] ModeLongB   = 3'd2;
  localparam logic [ModeW-1:0] ModeShort0  = 3'd3;
  localparam logic [ModeW-1:0] ModeLast    = 3'd6;

  typedef enum logic [CfgAddrW-1:0] {
    RegTenthPeriod  = 3'd0,
    RegCountDown    = 3'd1,
    RegAdcPeriod    = 3'd2,
    RegStartupDwell = 3'd3,
    RegLongDwell    = 3'd4,
    RegShortDwell   = 3'd5,
    RegPingReload   = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [DigitW-1:0] minutes;
    logic [TensW-1:0]  sec_tens;
    logic [DigitW-1:0] sec_units;
    logic [DigitW-1:0] tenths;
  } digits_t;

  // stopwatch step control from the sequencer to the digit counter
  typedef struct packed {
    logic step;
    logic down;
  } sw_ctrl_t;

endpackage

`default_nettype wire

@@ sv/bsms_stopwatch.sv @@
// ----------------------------------------------------------------------------
// bsms_stopwatch
// Four-digit BCD stopwatch M:SS.t counting up or down by one tenth per step.
// ----------------------------------------------------------------------------
`default_nettype none

module bsms_stopwatch
  import bsms_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire sw_ctrl_t ctrl_i,
  output digits_t       digits_o
);

  digits_t digits_q, digits_d;

  // one digit of the chain: returns {carry_out, next_digit}
  function automatic logic [DigitW:0] step_digit(input logic [DigitW-1:0] d,
                                                 input logic [DigitW-1:0] lim,
                                                 input logic down,
                                                 input logic carry);
    logic [DigitW:0] r;
    r = {1'b0, d};
    if (carry) begin
      if (down) begin
        if (d == '0 || d > lim) begin
          r = {1'b1, lim};
        end else begin
          r = {1'b0, d - 1'b1};
        end
      end else begin
        if (d >= lim) begin
          r = {1'b1, {DigitW{1'b0}}};
        end else begin
          r = {1'b0, d + 1'b1};
        end
      end
    end
    return r;
  endfunction

  logic [DigitW:0] s0, s1, s2, s3;

  always_comb begin
    s0 = step_digit(digits_q.tenths, DigitMax, ctrl_i.down, 1'b1);
    s1 = step_digit(digits_q.sec_units, DigitMax, ctrl_i.down, s0[DigitW]);
    s2 = step_digit({1'b0, digits_q.sec_tens}, TensMax, ctrl_i.down, s1[DigitW]);
    s3 = step_digit(digits_q.minutes, DigitMax, ctrl_i.down, s2[DigitW]);
    digits_d = digits_q;
    if (ctrl_i.step) begin
      digits_d.tenths    = s0[DigitW-1:0];
      digits_d.sec_units = s1[DigitW-1:0];
      digits_d.sec_tens  = s2[TensW-1:0];
      digits_d.minutes   = s3[DigitW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digits_q <= '0;
    end else begin
      digits_q <= digits_d;
    end
  end

  assign digits_o = digits_q;

endmodule

`default_nettype wire

@@ sv/bcd_stopwatch_mode_sequencer.sv @@
// ----------------------------------------------------------------------------
// bcd_stopwatch_mode_sequencer
// Tick-driven BCD stopwatch, ADC start prescaler, ping countdown and
// seven-state display-mode sequencer.
// ----------------------------------------------------------------------------
//  channel   | dir | tdata                                | tuser
//  s_axis    | in  | new_mode[2:0], zero pad to 8 bits    | func
//  m_axis    | out | tenths, sec units, sec tens, minutes,| -
//            |     | mode, adc_start, ping (27b, pad 32)  |
//  cfg       | in  | write enable, 3-bit index, 16-bit data, no read-back
//
//  One request per cycle sustained while m_axis is not stalled: a request
//  sits in the input register, the counter update runs while it is there,
//  and the result lands in the output register at the edge that moves it
//  on, so it is offered on m_axis from that register. A stalled m_axis
//  holds the output register; the input register takes a new request when
//  it is empty or whenever its content moves on in the same cycle.
//  Reset clears all counters, the digits and the mode (startup mode).
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_stopwatch_mode_sequencer
  import bsms_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // request: tdata = {pad, new_mode[2:0]}, tuser = func
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  wire logic [7:0]          s_axis_tdata_i,
  input  wire logic                s_axis_tuser_i,
  // result: [3:0] tenths, [7:4] sec units, [10:8] sec tens, [14:11] minutes,
  //         [17:15] display mode, [18] adc_start, [26:19] ping, [31:27] zero
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output logic [31:0]              m_axis_tdata_o,
  // configuration
  input  wire logic                cfg_we_i,
  input  wire logic [CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i
);

  // configuration registers
  logic [PrescaleW-1:0] tenth_period_q, adc_period_q;
  logic [PrescaleW-1:0] startup_dwell_q, long_dwell_q, short_dwell_q;
  logic                 count_down_q;
  logic [PingW-1:0]     ping_reload_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tenth_period_q  <= 16'd99;
      count_down_q    <= 1'b0;
      adc_period_q    <= 16'd99;
      startup_dwell_q <= 16'd3000;
      long_dwell_q    <= 16'd4000;
      short_dwell_q   <= 16'd2000;
      ping_reload_q   <= 8'd100;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegTenthPeriod:  tenth_period_q  <= cfg_wdata_i;
        RegCountDown:    count_down_q    <= cfg_wdata_i[0];
        RegAdcPeriod:    adc_period_q    <= cfg_wdata_i;
        RegStartupDwell: startup_dwell_q <= cfg_wdata_i;
        RegLongDwell:    long_dwell_q    <= cfg_wdata_i;
        RegShortDwell:   short_dwell_q   <= cfg_wdata_i;
        RegPingReload:   ping_reload_q   <= cfg_wdata_i[PingW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic             in_valid_q;
  logic             in_func_q;
  logic [ModeW-1:0] in_mode_q;
  logic             advance;
  logic             out_valid_q;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_func_q <= s_axis_tuser_i;
      in_mode_q <= s_axis_tdata_i[ModeW-1:0];
    end
  end

  // working state
  logic [PrescaleW-1:0] tenth_pre_q, tenth_pre_d;
  logic [PrescaleW-1:0] adc_pre_q, adc_pre_d;
  logic [PrescaleW-1:0] dwell_q, dwell_d, dwell_inc;
  logic [ModeW-1:0]     mode_q, mode_d;
  logic [PingW-1:0]     ping_q, ping_d;
  logic                 adc_fire;
  logic                 is_tick;
  sw_ctrl_t             sw_ctrl;
  digits_t              digits;

  assign is_tick   = advance && !in_func_q;
  assign dwell_inc = dwell_q + 1'b1;

  always_comb begin
    tenth_pre_d  = tenth_pre_q;
    adc_pre_d    = adc_pre_q;
    dwell_d      = dwell_q;
    mode_d       = mode_q;
    ping_d       = ping_q;
    adc_fire     = 1'b0;
    sw_ctrl.step = 1'b0;
    sw_ctrl.down = count_down_q;

    if (advance && in_func_q) begin
      // force mode; code seven means nothing and is dropped
      if (in_mode_q <= ModeLast) begin
        mode_d = in_mode_q;
      end
    end else if (is_tick) begin
      if (tenth_pre_q >= tenth_period_q) begin
        tenth_pre_d  = '0;
        sw_ctrl.step = 1'b1;
      end else begin
        tenth_pre_d = tenth_pre_q + 1'b1;
      end

      if (adc_pre_q >= adc_period_q) begin
        adc_pre_d = '0;
        adc_fire  = 1'b1;
      end else begin
        adc_pre_d = adc_pre_q + 1'b1;
      end

      if (ping_q != '0) begin
        ping_d = ping_q - 1'b1;
      end

      dwell_d = dwell_inc;
      priority if (mode_q == ModeStartup) begin
        if (dwell_inc >= startup_dwell_q) begin
          ping_d  = ping_reload_q;
          dwell_d = '0;
        end
      end else if (mode_q <= ModeLongB) begin
        if (dwell_inc >= long_dwell_q) begin
          mode_d  = (mode_q == ModeLongA) ? ModeLongB : ModeLongA;
          dwell_d = '0;
        end
      end else if (mode_q <= ModeLast) begin
        if (dwell_inc >= short_dwell_q) begin
          mode_d  = (mode_q == ModeLast) ? ModeShort0 : mode_q + 1'b1;
          dwell_d = '0;
        end
      end else begin
        // no such mode; hold
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tenth_pre_q <= '0;
      adc_pre_q   <= '0;
      dwell_q     <= '0;
      mode_q      <= ModeStartup;
      ping_q      <= '0;
    end else begin
      tenth_pre_q <= tenth_pre_d;
      adc_pre_q   <= adc_pre_d;
      dwell_q     <= dwell_d;
      mode_q      <= mode_d;
      ping_q      <= ping_d;
    end
  end

  bsms_stopwatch u_stopwatch (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (sw_ctrl),
    .digits_o (digits)
  );

  // digit register, already past this request's step in the cycle after
  // the advance
  digits_t digits_next;
  logic    out_adc_q;

  // the counter updates at the advance edge; capture its value in the
  // following cycle, marked by pend_q
  assign digits_next = digits;

  logic [ModeW-1:0] out_mode_q;
  logic [PingW-1:0] out_ping_q;
  logic             pend_q;

  // output register: the digit field is sampled when the pending mark is set
  digits_t out_digits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      pend_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_mode_q <= mode_d;
      out_ping_q <= ping_d;
      out_adc_q  <= adc_fire;
    end
    if (pend_q) begin
      out_digits_q <= digits_next;
    end
  end

  // digits register holds the value after the advance in the cycle after it,
  // and the output register is valid in that same cycle, so show the live
  // digits in that cycle and the captured copy while stalled afterwards
  digits_t shown_digits;
  assign shown_digits = pend_q ? digits_next : out_digits_q;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b0, out_ping_q, out_adc_q, out_mode_q,
                            shown_digits.minutes, shown_digits.sec_tens,
                            shown_digits.sec_units, shown_digits.tenths};

endmodule

`default_nettype wire

@@ tb/bcd_stopwatch_mode_sequencer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_stopwatch_mode_sequencer_tb
// Sends tick and mode-force requests to the stopwatch and mode sequencer,
// predicts readouts with a software copy of its counters or a scripted value and checks
// each result field by field, under random stalls on both streams and
// across several register settings, the extremes among them.
// ----------------------------------------------------------------------------
module bcd_stopwatch_mode_sequencer_tb;
  import bsms_pkg::*;

  localparam logic [CfgAddrW-1:0] RegUnused = 3'd7;
  localparam logic FuncTick  = 1'b0;
  localparam logic FuncForce = 1'b1;
  localparam int   ItemsPerSetting = 208;
  localparam int   MaxPrinted = 40;

  typedef struct packed {
    logic [PingW-1:0] ping;
    logic             adc;
    logic [ModeW-1:0] mode;
    digits_t          digits;
  } readout_t;

  localparam int ReadoutW = $bits(readout_t);

  typedef enum logic [1:0] { RowTick, RowForce, RowWrite } row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    logic [CfgAddrW-1:0] arg;   // new mode or register index
    logic [CfgDataW-1:0] value;
    logic                typed;
    readout_t            want;
  } script_row_t;

  localparam readout_t AllClear   = '0;
  localparam readout_t ForcedLast = '{ping: '0, adc: 1'b0, mode: ModeLast, digits: '0};
  localparam readout_t WrapDown   = '{ping: '0, adc: 1'b1, mode: ModeLast,
      digits: '{minutes: 4'd9, sec_tens: 3'd5, sec_units: 4'd9, tenths: 4'd9}};
  localparam int ScriptLen = 37;

  script_row_t script [ScriptLen] = '{
    '{RowTick,  3'd0,            16'd0,     1'b1, AllClear},
    '{RowForce, 3'd7,            16'd0,     1'b1, AllClear},
    '{RowForce, ModeLast,        16'd0,     1'b1, ForcedLast},
    '{RowTick,  3'd0,            16'd0,     1'b0, AllClear},
    '{RowWrite, RegTenthPeriod,  16'd0,     1'b0, AllClear},
    '{RowWrite, RegAdcPeriod,    16'd0,     1'b0, AllClear},
    '{RowWrite, RegCountDown,    16'd1,     1'b0, AllClear},
    '{RowTick,  3'd0,            16'd0,     1'b1, WrapDown},
    '{RowWrite, RegCountDown,    16'd0,     1'b0, AllClear},
    '{RowTick,  3'd0,            16'd0,     1'b0, AllClear},
    '{RowTick,  3'd0,            16'd0,     1'b0, AllClear},
    '{RowWrite, RegStartupDwell, 16'd0,     1'b0, AllClear},
    '{RowWrite, RegPingReload,   16'd255,   1'b0, AllClear},
    '{RowForce, ModeStartup,     16'd0,     1'b0, AllClear},
    '{RowTick,  3'd0,            16'd0,     1'b0, AllClear},
    '{RowWrite, RegStartupDwell, 16'hffff,  1'b0, AllClear},
    '{RowTick,  3'd0,            16'd0,     1'b0, AllClear},
    '{RowWrite, RegPingReload,   16'd0,     1'b0, AllClear},
    '{RowWrite, RegStartupDwell, 16'd1,     1'b0, AllClear},
    '{RowTick,  3'd0,            16'd0,     1'b0, AllClear},
    '{RowTick,  3'd0,            16'd0,     1'b0, AllClear},
    '{RowWrite, RegLongDwell,    16'd0,     1'b0, AllClear},
    '{RowForce, ModeLongA,       16'd0,     1'b0, AllClear},
    '{RowTick,  3'd0,            16'd0,     1'b0, AllClear},
    '{RowTick,  3'd0,            16'd0,     1'b0, AllClear},
    '{RowWrite, RegShortDwell,   16'd1,     1'b0, AllClear},
    '{RowForce, ModeLast,        16'd0,     1'b0, AllClear},
    '{RowTick,  3'd0,            16'd0,     1'b0, AllClear},
    '{RowForce, 3'd5,            16'd0,     1'b0, AllClear},
    '{RowTick,  3'd0,            16'd0,     1'b0, AllClear},
    '{RowWrite, RegUnused,       16'hffff,  1'b0, AllClear},
    '{RowWrite, RegTenthPeriod,  16'hffff,  1'b0, AllClear},
    '{RowWrite, RegAdcPeriod,    16'hffff,  1'b0, AllClear},
    '{RowTick,  3'd0,            16'd0,     1'b0, AllClear},
    '{RowForce, ModeShort0,      16'd0,     1'b0, AllClear},
    '{RowForce, 3'd4,            16'd0,     1'b0, AllClear},
    '{RowTick,  3'd0,            16'd0,     1'b0, AllClear}
  };

  logic                clk_i;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [7:0]          s_axis_tdata_i  = '0;   // [2:0] new_mode, [7:3] zero
  logic                s_axis_tuser_i  = 1'b0; // [0] func
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [31:0]         m_axis_tdata_o;         // tenths, units, tens, minutes,
                                               // mode, adc_start, ping
  logic                cfg_we_i    = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i  = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  // register copies
  logic [CfgDataW-1:0] tenth_period_q, adc_period_q;
  logic [CfgDataW-1:0] startup_dwell_q, long_dwell_q, short_dwell_q;
  logic                count_down_q;
  logic [PingW-1:0]    ping_reload_q;

  // counter copies
  logic [PrescaleW-1:0] tenth_div, adc_div, dwell_ticks;
  logic [ModeW-1:0]     mode_now;
  logic [PingW-1:0]     ping_left;
  logic [DigitW-1:0]    digit_q [4];

  readout_t    pending_readouts [$];
  int unsigned n_errors      = 0;
  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;

  bcd_stopwatch_mode_sequencer DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (n_errors < MaxPrinted) begin
      $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
    end
    n_errors++;
  endtask

  // Advance the counter copies by one request and return the readout it yields.
  function automatic readout_t next_readout(input logic func,
                                            input logic [ModeW-1:0] req_mode);
    readout_t          r;
    logic              fired;
    logic              carry;
    logic [DigitW-1:0] lim;
    fired = 1'b0;
    if (func == FuncForce) begin
      if (req_mode <= ModeLast) mode_now = req_mode;
    end else begin
      if (tenth_div >= tenth_period_q) begin
        tenth_div = '0;
        carry = 1'b1;
        for (int p = 0; p < 4; p++) begin
          lim = (p == 2) ? TensMax : DigitMax;
          if (carry) begin
            if (count_down_q) begin
              if (digit_q[p] == '0 || digit_q[p] > lim) begin
                digit_q[p] = lim;
              end else begin
                digit_q[p] = digit_q[p] - 1'b1;
                carry = 1'b0;
              end
            end else if (digit_q[p] >= lim) begin
              digit_q[p] = '0;
            end else begin
              digit_q[p] = digit_q[p] + 1'b1;
              carry = 1'b0;
            end
          end
        end
      end else begin
        tenth_div = tenth_div + 1'b1;
      end
      if (adc_div >= adc_period_q) begin
        adc_div = '0;
        fired = 1'b1;
      end else begin
        adc_div = adc_div + 1'b1;
      end
      if (ping_left != '0) ping_left = ping_left - 1'b1;
      dwell_ticks = dwell_ticks + 1'b1;
      if (mode_now == ModeStartup) begin
        // reload lands after this tick's decrement
        if (dwell_ticks >= startup_dwell_q) begin
          ping_left = ping_reload_q;
          dwell_ticks = '0;
        end
      end else if (mode_now <= ModeLongB) begin
        if (dwell_ticks >= long_dwell_q) begin
          mode_now = (mode_now == ModeLongA) ? ModeLongB : ModeLongA;
          dwell_ticks = '0;
        end
      end else if (dwell_ticks >= short_dwell_q) begin
        mode_now = (mode_now == ModeLast) ? ModeShort0 : mode_now + 1'b1;
        dwell_ticks = '0;
      end
    end
    r.digits.tenths    = digit_q[0];
    r.digits.sec_units = digit_q[1];
    r.digits.sec_tens  = digit_q[2][TensW-1:0];
    r.digits.minutes   = digit_q[3];
    r.mode             = mode_now;
    r.adc              = fired;
    r.ping             = ping_left;
    return r;
  endfunction

  function automatic logic [CfgDataW-1:0] pick_value(input int setting,
                                                     input logic [CfgAddrW-1:0] idx);
    logic [CfgDataW-1:0] top;
    int unsigned         near_hi;
    int unsigned         draw;
    case (idx)
      RegCountDown:   begin top = 16'd1;    near_hi = 1;   end
      RegPingReload:  begin top = 16'd255;  near_hi = 255; end
      RegTenthPeriod: begin top = 16'hffff; near_hi = 9;   end
      RegAdcPeriod:   begin top = 16'hffff; near_hi = 15;  end
      default:        begin top = 16'hffff; near_hi = 40;  end
    endcase
    // setting 1 is all minimums, setting 5 all maximums
    draw = (setting == 1) ? 0 : (setting == 5) ? 1 : $urandom_range(0, 9);
    if (draw == 0) return '0;
    if (draw == 1) return top;
    return CfgDataW'($urandom_range(0, near_hi));
  endfunction

  task automatic send_request(input logic func, input logic [ModeW-1:0] req_mode,
                              input logic typed, input readout_t want);
    readout_t r;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {5'b0, req_mode};
    s_axis_tuser_i  <= func;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    r = next_readout(func, req_mode);
    pending_readouts.push_back(typed ? want : r);
  endtask

  // Hold requests until every readout is back, then let the pipeline settle.
  task automatic drain_readouts();
    s_axis_tvalid_i <= 1'b0;
    while (pending_readouts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] idx,
                           input logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      RegTenthPeriod:  tenth_period_q  = val;
      RegCountDown:    count_down_q    = val[0];
      RegAdcPeriod:    adc_period_q    = val;
      RegStartupDwell: startup_dwell_q = val;
      RegLongDwell:    long_dwell_q    = val;
      RegShortDwell:   short_dwell_q   = val;
      RegPingReload:   ping_reload_q   = val[PingW-1:0];
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin : readout_check
    readout_t got;
    readout_t want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[ReadoutW-1:0];
      if (pending_readouts.size() == 0) begin
        report_mismatch("result with nothing pending", m_axis_tdata_o, '0);
      end else begin
        want = pending_readouts.pop_front();
        if (got.digits.tenths !== want.digits.tenths)
          report_mismatch("tenths_digit", 32'(got.digits.tenths),
                          32'(want.digits.tenths));
        if (got.digits.sec_units !== want.digits.sec_units)
          report_mismatch("seconds_units", 32'(got.digits.sec_units),
                          32'(want.digits.sec_units));
        if (got.digits.sec_tens !== want.digits.sec_tens)
          report_mismatch("seconds_tens", 32'(got.digits.sec_tens),
                          32'(want.digits.sec_tens));
        if (got.digits.minutes !== want.digits.minutes)
          report_mismatch("minutes_digit", 32'(got.digits.minutes),
                          32'(want.digits.minutes));
        if (got.mode !== want.mode)
          report_mismatch("display_mode", 32'(got.mode), 32'(want.mode));
        if (got.adc !== want.adc)
          report_mismatch("adc_start", 32'(got.adc), 32'(want.adc));
        if (got.ping !== want.ping)
          report_mismatch("ping_remaining", 32'(got.ping), 32'(want.ping));
        if (m_axis_tdata_o[31:ReadoutW] !== '0)
          report_mismatch("tdata pad", m_axis_tdata_o, '0);
      end
    end
    m_axis_tready_i <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  initial begin : stimulus
    int setting;
    tenth_period_q  = 16'd99;
    count_down_q    = 1'b0;
    adc_period_q    = 16'd99;
    startup_dwell_q = 16'd3000;
    long_dwell_q    = 16'd4000;
    short_dwell_q   = 16'd2000;
    ping_reload_q   = 8'd100;
    tenth_div       = '0;
    adc_div         = '0;
    dwell_ticks     = '0;
    mode_now        = ModeStartup;
    ping_left       = '0;
    foreach (digit_q[i]) digit_q[i] = '0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      case (script[i].kind)
        RowWrite: begin
          drain_readouts();
          write_reg(script[i].arg, script[i].value);
        end
        RowForce: send_request(FuncForce, script[i].arg, script[i].typed, script[i].want);
        default:  send_request(FuncTick, '0, script[i].typed, script[i].want);
      endcase
    end

    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct  = (ph == 0) ? 31 : (ph == 1) ? 87 : 0;
      sink_idle_pct = (ph == 0) ? 87 : (ph == 1) ? 31 : 0;
      for (int s = 0; s < 3; s++) begin
        setting = 3 * ph + s;
        drain_readouts();
        for (int r = RegTenthPeriod; r <= RegPingReload; r++) begin
          write_reg(CfgAddrW'(r), pick_value(setting, CfgAddrW'(r)));
        end
        if ($urandom_range(0, 1)) write_reg(RegUnused, CfgDataW'($urandom));
        for (int n = 0; n < ItemsPerSetting; n++) begin
          if ($urandom_range(0, 249) == 0) drain_readouts();
          if ($urandom_range(0, 99) < 15) begin
            send_request(FuncForce, ModeW'($urandom_range(0, 7)), 1'b0, AllClear);
          end else begin
            send_request(FuncTick, ModeW'($urandom_range(0, 7)), 1'b0, AllClear);
          end
        end
      end
    end

    drain_readouts();
    repeat (8) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("PASS bcd_stopwatch_mode_sequencer");
    end else begin
      $display("FAIL bcd_stopwatch_mode_sequencer");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("FAIL bcd_stopwatch_mode_sequencer");
    $finish;
  end

endmodule
